// ----- sv/stp_pkg.sv -----
package stp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned NRM_FRAC = 14;

	localparam logic [1:0] CFG_VERTEX_A = 2'd0;
	localparam logic [1:0] CFG_VERTEX_B = 2'd1;
	localparam logic [1:0] CFG_VERTEX_C = 2'd2;

	typedef logic signed [15:0] c16_t;
	typedef logic signed [16:0] e17_t;
	typedef logic signed [17:0] p18_t;
	typedef logic signed [34:0] d35_t;
	typedef logic signed [71:0] den_t;

	typedef c16_t [2:0] vec16_t;
	typedef e17_t [2:0] vec17_t;
	typedef p18_t [2:0] vec18_t;

	// one query after the front stage: position, center relative to vertex a, radius
	typedef struct packed {
		vec16_t      obj;
		vec18_t      p;
		logic [14:0] rad;
	} item_t;

	// triangle constants derived from the vertex registers
	typedef struct packed {
		logic   ok;
		vec16_t a;
		vec16_t n;
		vec17_t e0;
		vec17_t e1;
		d35_t   d00;
		d35_t   d01;
		d35_t   d11;
		den_t   den;
	} tgl_t;

endpackage

// ----- sv/sphere_triangle_pushout_top.sv -----
// Sphere versus triangle contact with push-out.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the three
// packed vertices a, b, c (x in 15:0, y in 31:16, z in 47:32); index 3 is
// ignored. cfg_ready is always high. Each write restarts the triangle setup
// unit (normal, edge dots, denominator), which stops early when the cross
// product is zero; in_ready stays low while it runs. The normalize loop,
// the bit-serial square root and the three serial divides set its run time.
// Input channel (in_valid/in_ready) takes position, collider offset and
// radius; output channel (out_valid/out_ready) returns hit and the corrected
// position. One transaction per cycle is sustained while out_ready is high
// and no setup runs, through the front register, the queue and eight back
// stages. A two-entry queue sits between the front register and the back
// pipeline; when out_ready is low the back pipeline holds, the queue fills,
// and then in_ready drops. After reset the vertices are zero: every query
// misses and passes the position through until a triangle is written.
module sphere_triangle_pushout_top #(
	parameter int unsigned Q_DEPTH = stp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  stp_pkg::c16_t      object_x,
	input  stp_pkg::c16_t      object_y,
	input  stp_pkg::c16_t      object_z,
	input  stp_pkg::c16_t      offset_x,
	input  stp_pkg::c16_t      offset_y,
	input  stp_pkg::c16_t      offset_z,
	input  logic [14:0]        radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output stp_pkg::c16_t      new_x,
	output stp_pkg::c16_t      new_y,
	output stp_pkg::c16_t      new_z
);
	import stp_pkg::*;

	logic [47:0] va_q, vb_q, vc_q;
	logic cfg_wr, busy;
	tgl_t tgl;
	vec16_t obj_v, off_v, new_v;
	logic push_valid, push_ready, pop_valid, pop_ready;
	item_t push_item, pop_item;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_VERTEX_A: va_q <= cfg_data;
				CFG_VERTEX_B: vb_q <= cfg_data;
				CFG_VERTEX_C: vc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	stp_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.va     (va_q),
		.vb     (vb_q),
		.vc     (vc_q),
		.busy   (busy),
		.tgl    (tgl)
	);

	always_comb begin
		obj_v[0] = object_x;
		obj_v[1] = object_y;
		obj_v[2] = object_z;
		off_v[0] = offset_x;
		off_v[1] = offset_y;
		off_v[2] = offset_z;
	end

	stp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.busy       (busy),
		.a          (tgl.a),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.obj        (obj_v),
		.off        (off_v),
		.rad        (radius),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	stp_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	stp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tgl       (tgl),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_item    (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.new_pos   (new_v)
	);

	assign new_x = new_v[0];
	assign new_y = new_v[1];
	assign new_z = new_v[2];

endmodule

// ----- sv/stp_setup.sv -----
module stp_setup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [47:0]   va,
	input  logic [47:0]   vb,
	input  logic [47:0]   vc,
	output logic          busy,
	output stp_pkg::tgl_t tgl
);
	import stp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CROSS = 9'b000000010,
		ST_MAX   = 9'b000000100,
		ST_NORM  = 9'b000001000,
		ST_SQ    = 9'b000010000,
		ST_SQRT  = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_DEN0  = 9'b010000000,
		ST_DEN1  = 9'b100000000
	} st_t;

	localparam logic [5:0]  DIV_TOP = 6'd36;
	localparam logic [42:0] SQRT_BIT0 = 43'd1 << 42;

	st_t state_q, state_d;
	logic ok_q;
	logic [1:0] sq_cnt_q, j_q;
	logic [5:0] idx_q;

	vec16_t a_v, b_v, c_v;
	e17_t e0_c [3];
	e17_t e1_c [3];
	e17_t e2_c [3];
	logic signed [35:0] cr_c [3];
	d35_t d00_c, d01_c, d11_c;

	logic signed [35:0] cr_q [3];
	logic [35:0] tmag_q [3];
	logic neg_q [3];
	logic [35:0] m_q;
	logic [42:0] sum_q, sum_d, sv_q, sr_q, sbit_q, st_c;
	logic [41:0] sq_c;
	logic [20:0] tsel_c;
	logic [21:0] len_q;
	logic [22:0] rem_q, rem_n;
	logic [15:0] quo_q, q_new;
	logic [36:0] num_c;
	logic [23:0] trial_c, div_c;
	logic ge_c;
	vec16_t n_q;
	vec16_t a_q;
	vec17_t e0_q, e1_q;
	d35_t d00_q, d01_q, d11_q;
	logic signed [53:0] pp_q [4];
	den_t den_q, den_c, x0, x1, x2, x3;
	logic m_big, m_small;

	assign a_v = va;
	assign b_v = vb;
	assign c_v = vc;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e0_c[i] = e17_t'(b_v[i]) - e17_t'(a_v[i]);
			e1_c[i] = e17_t'(c_v[i]) - e17_t'(a_v[i]);
			e2_c[i] = e17_t'(c_v[i]) - e17_t'(b_v[i]);
		end
		cr_c[0] = e0_c[1] * e2_c[2] - e0_c[2] * e2_c[1];
		cr_c[1] = e0_c[2] * e2_c[0] - e0_c[0] * e2_c[2];
		cr_c[2] = e0_c[0] * e2_c[1] - e0_c[1] * e2_c[0];
		d00_c = e0_c[0] * e0_c[0] + e0_c[1] * e0_c[1] + e0_c[2] * e0_c[2];
		d01_c = e0_c[0] * e1_c[0] + e0_c[1] * e1_c[1] + e0_c[2] * e1_c[2];
		d11_c = e1_c[0] * e1_c[0] + e1_c[1] * e1_c[1] + e1_c[2] * e1_c[2];
	end

	assign m_big   = (m_q[35:20] != '0);
	assign m_small = !m_q[19];

	// sum of squares, one component per cycle
	assign tsel_c = tmag_q[sq_cnt_q][20:0];
	assign sq_c   = tsel_c * tsel_c;
	assign sum_d  = sum_q + 43'(sq_c);

	// integer square root by trial subtraction, bit by bit
	assign st_c = sr_q + sbit_q;

	// restoring divide: (|t| * 2^15 + len) / (2 * len), one quotient bit per cycle
	assign num_c   = {tmag_q[j_q][20:0], 15'd0} + 37'(len_q);
	assign div_c   = {1'b0, len_q, 1'b0};
	assign trial_c = {rem_q, num_c[idx_q]};
	assign ge_c    = (trial_c >= div_c);
	assign rem_n   = ge_c ? 23'(trial_c - div_c) : trial_c[22:0];
	assign q_new   = {quo_q[14:0], ge_c};

	always_comb begin
		x0 = den_t'(pp_q[0]);
		x1 = den_t'(pp_q[1]);
		x2 = den_t'(pp_q[2]);
		x3 = den_t'(pp_q[3]);
		den_c = (x1 <<< 18) + x0 - (x3 <<< 18) - x2;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  state_d = ST_IDLE;
			ST_CROSS: state_d = ST_MAX;
			ST_MAX:   state_d = ST_NORM;
			ST_NORM: begin
				if (m_q == '0)
					state_d = ST_IDLE;
				else if (!m_big && !m_small)
					state_d = ST_SQ;
			end
			ST_SQ: begin
				if (sq_cnt_q == 2'd2)
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sbit_q == '0)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (idx_q == '0 && j_q == 2'd2)
					state_d = ST_DEN0;
			end
			ST_DEN0:  state_d = ST_DEN1;
			ST_DEN1:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
		if (start)
			state_d = ST_CROSS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ok_q     <= 1'b0;
			sq_cnt_q <= '0;
			j_q      <= '0;
			idx_q    <= DIV_TOP;
		end else begin
			state_q <= state_d;
			if (start)
				ok_q <= 1'b0;
			else if (state_q == ST_NORM && m_q == '0)
				ok_q <= 1'b0;
			else if (state_q == ST_DEN1)
				ok_q <= (den_c != '0) && !den_c[71];
			if (state_q == ST_NORM)
				sq_cnt_q <= '0;
			else if (state_q == ST_SQ)
				sq_cnt_q <= sq_cnt_q + 2'd1;
			if (state_q == ST_SQRT) begin
				j_q   <= '0;
				idx_q <= DIV_TOP;
			end else if (state_q == ST_DIV) begin
				if (idx_q == '0) begin
					idx_q <= DIV_TOP;
					j_q   <= j_q + 2'd1;
				end else begin
					idx_q <= idx_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					cr_q[i] <= cr_c[i];
					e0_q[i] <= e0_c[i];
					e1_q[i] <= e1_c[i];
				end
				a_q   <= a_v;
				d00_q <= d00_c;
				d01_q <= d01_c;
				d11_q <= d11_c;
			end
			ST_MAX: begin
				logic [35:0] mg [3];
				for (int i = 0; i < 3; i++) begin
					mg[i] = cr_q[i][35] ? 36'(-cr_q[i]) : 36'(cr_q[i]);
					tmag_q[i] <= mg[i];
					neg_q[i]  <= cr_q[i][35];
				end
				if (mg[0] >= mg[1] && mg[0] >= mg[2])
					m_q <= mg[0];
				else if (mg[1] >= mg[2])
					m_q <= mg[1];
				else
					m_q <= mg[2];
			end
			ST_NORM: begin
				if (m_big) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++)
						tmag_q[i] <= tmag_q[i] >> 1;
				end else if (m_small) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++)
						tmag_q[i] <= tmag_q[i] << 1;
				end
				sum_q <= '0;
			end
			ST_SQ: begin
				sum_q <= sum_d;
				if (sq_cnt_q == 2'd2) begin
					sv_q   <= sum_d;
					sr_q   <= '0;
					sbit_q <= SQRT_BIT0;
				end
			end
			ST_SQRT: begin
				if (sbit_q == '0) begin
					len_q <= sr_q[21:0];
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					if (sv_q >= st_c) begin
						sv_q <= sv_q - st_c;
						sr_q <= (sr_q >> 1) + sbit_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
			end
			ST_DIV: begin
				if (idx_q == '0) begin
					n_q[j_q] <= neg_q[j_q] ? -$signed(q_new) : $signed(q_new);
					rem_q    <= '0;
					quo_q    <= '0;
				end else begin
					rem_q <= rem_n;
					quo_q <= q_new;
				end
			end
			ST_DEN0: begin
				pp_q[0] <= d00_q * $signed({1'b0, d11_q[17:0]});
				pp_q[1] <= d00_q * $signed(d11_q[34:18]);
				pp_q[2] <= d01_q * $signed({1'b0, d01_q[17:0]});
				pp_q[3] <= d01_q * $signed(d01_q[34:18]);
			end
			ST_DEN1: den_q <= den_c;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		tgl.ok  = ok_q;
		tgl.a   = a_q;
		tgl.n   = n_q;
		tgl.e0  = e0_q;
		tgl.e1  = e1_q;
		tgl.d00 = d00_q;
		tgl.d01 = d01_q;
		tgl.d11 = d11_q;
		tgl.den = den_q;
	end

endmodule

// ----- sv/stp_front.sv -----
module stp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           busy,
	input  stp_pkg::vec16_t a,
	input  logic           in_valid,
	output logic           in_ready,
	input  stp_pkg::vec16_t obj,
	input  stp_pkg::vec16_t off,
	input  logic [14:0]    rad,
	output logic           push_valid,
	input  logic           push_ready,
	output stp_pkg::item_t push_item
);
	import stp_pkg::*;

	logic  f_v_q;
	item_t f_item_q;
	logic  acc;

	assign in_ready = !busy && (!f_v_q || push_ready);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			f_v_q <= 1'b0;
		else if (acc)
			f_v_q <= 1'b1;
		else if (push_ready)
			f_v_q <= 1'b0;
	end

	// sphere center relative to vertex a
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 3; i++)
				f_item_q.p[i] <= p18_t'(obj[i]) + p18_t'(off[i]) - p18_t'(a[i]);
			f_item_q.obj <= obj;
			f_item_q.rad <= rad;
		end
	end

	assign push_valid = f_v_q;
	assign push_item  = f_item_q;

endmodule

// ----- sv/stp_queue.sv -----
module stp_queue #(
	parameter int unsigned DEPTH = stp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  stp_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output stp_pkg::item_t pop_item
);
	import stp_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ----- sv/stp_back.sv -----
module stp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  stp_pkg::tgl_t  tgl,
	input  logic           q_valid,
	output logic           q_ready,
	input  stp_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           hit,
	output stp_pkg::vec16_t new_pos
);
	import stp_pkg::*;

	localparam logic [46:0] RND_HALF = 47'd1 << 27;

	typedef logic signed [46:0] w47_t;
	typedef logic signed [19:0] q20_t;
	typedef logic signed [36:0] d37_t;
	typedef logic signed [53:0] pp_t;
	typedef logic signed [73:0] w74_t;

	// x / 2^28 rounded half away from zero
	function automatic q20_t rnd28(input w47_t x);
		logic [46:0] mg;
		logic [18:0] m;
		mg = x[46] ? 47'(-x) : 47'(x);
		m = 19'((mg + RND_HALF) >> 28);
		return x[46] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic w74_t comb18(input pp_t lo, input pp_t hi);
		w74_t l, h;
		l = w74_t'(lo);
		h = w74_t'(hi);
		return (h <<< 18) + l;
	endfunction

	logic en;
	logic v1, v2, v3, v4, v5, v6, v7, v8;

	vec16_t obj_s1, obj_s2, obj_s3, obj_s4, obj_s5, obj_s6, obj_s7;
	vec18_t p_s1, p_s2, p_s3;
	logic [14:0] rad_s1, rad_s2;
	logic signed [33:0] pn_s1 [3];
	logic signed [34:0] d_s2;
	w47_t dn_s3 [3];
	w47_t nk_s3 [3];
	logic near_s3, near_s4, near_s5, near_s6, near_s7;
	logic dneg_s3;
	logic dnz_s3, dnz_s4, dnz_s5, dnz_s6, dnz_s7;
	q20_t q_s4 [3];
	vec16_t adj_s4, adj_s5, adj_s6, adj_s7;
	d37_t d02_s5, d12_s5;
	pp_t pp_s6 [8];
	w74_t vv_s7, ww_s7;
	logic hit_s8;
	vec16_t new_s8;

	logic [34:0] absd_c;
	logic signed [35:0] k_c;
	w74_t vw_c, dmv_c;

	assign en      = !v8 || out_ready;
	assign q_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
		end else if (en) begin
			v1 <= q_valid;
			v2 <= v1;
			v3 <= v2;
			v4 <= v3;
			v5 <= v4;
			v6 <= v5;
			v7 <= v6;
			v8 <= v7;
		end
	end

	assign absd_c = d_s2[34] ? 35'(-d_s2) : 35'(d_s2);
	assign k_c    = $signed({7'd0, rad_s2, 14'd0}) - $signed({1'b0, absd_c});
	assign vw_c   = vv_s7 + ww_s7;
	assign dmv_c  = w74_t'(tgl.den) - vw_c;

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: plane distance products
			for (int i = 0; i < 3; i++)
				pn_s1[i] <= tgl.n[i] * q_item.p[i];
			obj_s1 <= q_item.obj;
			p_s1   <= q_item.p;
			rad_s1 <= q_item.rad;

			// s2: signed distance with 14 extra fraction bits
			d_s2   <= 35'(pn_s1[0]) + 35'(pn_s1[1]) + 35'(pn_s1[2]);
			obj_s2 <= obj_s1;
			p_s2   <= p_s1;
			rad_s2 <= rad_s1;

			// s3: within radius, products for foot point and push-out
			for (int i = 0; i < 3; i++) begin
				dn_s3[i] <= $signed(d_s2[30:0]) * tgl.n[i];
				nk_s3[i] <= tgl.n[i] * $signed({1'b0, k_c[29:0]});
			end
			near_s3 <= !k_c[35];
			dneg_s3 <= d_s2[34];
			dnz_s3  <= (d_s2 != '0);
			obj_s3  <= obj_s2;
			p_s3    <= p_s2;

			// s4: foot point and saturated corrected position
			for (int i = 0; i < 3; i++) begin
				logic signed [20:0] sm;
				q20_t corr;
				q_s4[i] <= q20_t'(p_s3[i]) - rnd28(dn_s3[i]);
				corr = rnd28(nk_s3[i]);
				sm = 21'(obj_s3[i]) + (dneg_s3 ? 21'(-corr) : 21'(corr));
				if (sm > 21'sd32767)
					adj_s4[i] <= 16'sh7FFF;
				else if (sm < -21'sd32768)
					adj_s4[i] <= 16'sh8000;
				else
					adj_s4[i] <= sm[15:0];
			end
			near_s4 <= near_s3;
			dnz_s4  <= dnz_s3;
			obj_s4  <= obj_s3;

			// s5: edge dot products with the foot point
			d02_s5 <= d37_t'(tgl.e0[0]) * d37_t'(q_s4[0])
				+ d37_t'(tgl.e0[1]) * d37_t'(q_s4[1])
				+ d37_t'(tgl.e0[2]) * d37_t'(q_s4[2]);
			d12_s5 <= d37_t'(tgl.e1[0]) * d37_t'(q_s4[0])
				+ d37_t'(tgl.e1[1]) * d37_t'(q_s4[1])
				+ d37_t'(tgl.e1[2]) * d37_t'(q_s4[2]);
			near_s5 <= near_s4;
			dnz_s5  <= dnz_s4;
			obj_s5  <= obj_s4;
			adj_s5  <= adj_s4;

			// s6: barycentric numerators, split into 18-bit low and high halves
			pp_s6[0] <= tgl.d11 * $signed({1'b0, d02_s5[17:0]});
			pp_s6[1] <= tgl.d11 * $signed(d02_s5[36:18]);
			pp_s6[2] <= tgl.d01 * $signed({1'b0, d12_s5[17:0]});
			pp_s6[3] <= tgl.d01 * $signed(d12_s5[36:18]);
			pp_s6[4] <= tgl.d00 * $signed({1'b0, d12_s5[17:0]});
			pp_s6[5] <= tgl.d00 * $signed(d12_s5[36:18]);
			pp_s6[6] <= tgl.d01 * $signed({1'b0, d02_s5[17:0]});
			pp_s6[7] <= tgl.d01 * $signed(d02_s5[36:18]);
			near_s6 <= near_s5;
			dnz_s6  <= dnz_s5;
			obj_s6  <= obj_s5;
			adj_s6  <= adj_s5;

			// s7: V and W
			vv_s7   <= comb18(pp_s6[0], pp_s6[1]) - comb18(pp_s6[2], pp_s6[3]);
			ww_s7   <= comb18(pp_s6[4], pp_s6[5]) - comb18(pp_s6[6], pp_s6[7]);
			near_s7 <= near_s6;
			dnz_s7  <= dnz_s6;
			obj_s7  <= obj_s6;
			adj_s7  <= adj_s6;

			// s8: inside test and output register
			begin
				logic h;
				h = tgl.ok && near_s7 && !vv_s7[73] && !ww_s7[73] && !dmv_c[73];
				hit_s8 <= h;
				new_s8 <= (h && dnz_s7) ? adj_s7 : obj_s7;
			end
		end
	end

	assign out_valid = v8;
	assign hit       = hit_s8;
	assign new_pos   = new_s8;

endmodule

// ----- sv/stp_checker.sv -----
module stp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cfg_valid,
	input logic          cfg_ready,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          hit,
	input stp_pkg::c16_t new_x,
	input stp_pkg::c16_t new_y,
	input stp_pkg::c16_t new_z
);
	logic [5:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (in_acc && !out_acc)
			cnt_q <= cnt_q + 6'd1;
		else if (out_acc && !in_acc)
			cnt_q <= cnt_q - 6'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({hit, new_x, new_y, new_z}))
		else $error("result changed while stalled");

	a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken while triangle setup runs");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 6'd0)
		else $error("result without a pending transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'd32)
		else $error("too many transactions in flight");

endmodule

bind sphere_triangle_pushout_top stp_checker u_chk (.*);
